// ===== rtl/tksort_pkg.sv =====
package tksort_pkg;

	localparam int unsigned MAX_ITEMS_DEF = 8;
	// largest batch the arrival index below can number
	localparam int unsigned MAX_ITEMS_LIM = 64;
	localparam int unsigned TAG_W         = 8;
	localparam int unsigned PRI_W         = 8;
	localparam int unsigned NAME_W        = 64;
	localparam int unsigned SEQ_W         = $clog2(MAX_ITEMS_LIM);

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [PRI_W-1:0]  primary;
		logic [NAME_W-1:0] name;
	} entry_t;

	// seq: arrival index within the batch
	typedef struct packed {
		logic             vld;
		logic [SEQ_W-1:0] seq;
		entry_t           ent;
	} slot_t;

	// per-cell control from the sequencer
	typedef struct packed {
		logic shift;   // unload toward cell 0
	} cell_ctrl_t;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	// true when a must be ordered after b; arrival index settles equal keys
	function automatic logic goes_after(slot_t a, slot_t b);
		goes_after = {a.ent.primary, a.ent.name, a.seq} > {b.ent.primary, b.ent.name, b.seq};
	endfunction

endpackage

// ===== rtl/tksort_in_if.sv =====
interface tksort_in_if;
	logic                             valid;
	logic                             ready;
	logic [tksort_pkg::TAG_W-1:0]     item_tag;
	logic [tksort_pkg::PRI_W-1:0]     primary_key;
	logic [tksort_pkg::NAME_W-1:0]    name_key;
	logic                             batch_last;

	modport source (output valid, item_tag, primary_key, name_key, batch_last, input ready);
	modport sink   (input valid, item_tag, primary_key, name_key, batch_last, output ready);
endinterface

// ===== rtl/tksort_out_if.sv =====
interface tksort_out_if;
	logic                             valid;
	logic                             ready;
	logic [tksort_pkg::TAG_W-1:0]     out_tag;
	logic [tksort_pkg::PRI_W-1:0]     out_primary;
	logic [tksort_pkg::NAME_W-1:0]    out_name;
	logic                             out_last;
	logic                             dropped_flag;

	modport source (output valid, out_tag, out_primary, out_name, out_last, dropped_flag,
		input ready);
	modport sink   (input valid, out_tag, out_primary, out_name, out_last, dropped_flag,
		output ready);
endinterface

// ===== rtl/tksort_cell.sv =====
// One insertion cell: keeps the smaller entry, hands the larger one on.
module tksort_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  tksort_pkg::cell_ctrl_t ctrl,
	input  tksort_pkg::slot_t      din,    // from previous cell
	input  tksort_pkg::slot_t      nxt,    // held slot of next cell
	output tksort_pkg::slot_t      held,
	output tksort_pkg::slot_t      pass
);

	logic                             held_vld_q;
	tksort_pkg::entry_t               held_q;
	logic [tksort_pkg::SEQ_W-1:0]     held_seq_q;
	logic                             pass_vld_q;
	tksort_pkg::entry_t               pass_q;
	logic [tksort_pkg::SEQ_W-1:0]     pass_seq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= 1'b0;
			pass_vld_q <= 1'b0;
		end else if (ctrl.shift) begin
			held_vld_q <= nxt.vld;
			pass_vld_q <= 1'b0;
		end else begin
			pass_vld_q <= din.vld && held_vld_q;
			if (din.vld && !held_vld_q) begin
				held_vld_q <= 1'b1;
			end
		end
	end

	// equal keys are ordered by arrival index, so arrival order survives
	// even when a displaced older entry trails a newer one down the chain
	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			held_q     <= nxt.ent;
			held_seq_q <= nxt.seq;
		end else if (din.vld) begin
			if (!held_vld_q) begin
				held_q     <= din.ent;
				held_seq_q <= din.seq;
			end else if (tksort_pkg::goes_after(held, din)) begin
				held_q     <= din.ent;
				held_seq_q <= din.seq;
				pass_q     <= held_q;
				pass_seq_q <= held_seq_q;
			end else begin
				pass_q     <= din.ent;
				pass_seq_q <= din.seq;
			end
		end
	end

	assign held = '{vld: held_vld_q, seq: held_seq_q, ent: held_q};
	assign pass = '{vld: pass_vld_q, seq: pass_seq_q, ent: pass_q};

endmodule

// ===== rtl/two_key_stable_sorter.sv =====
// Two-key stable sorter.
// items  : one entry per transfer (tag, primary key, 64-bit name key,
//          batch_last). While loading, one transfer per cycle is taken.
// results: the batch in ascending order of primary key, then name key;
//          equal keys keep arrival order. out_last marks the final entry,
//          dropped_flag is set on every result of a batch that overflowed.
// Entries arriving with MAX_ITEMS already stored are discarded.
// After the transfer carrying batch_last the sequencer drains (the
// insertion chain settles), then gives one result per cycle from a
// registered output while the receiver accepts. An output stall also
// delays the start of the next batch.
// items.ready is low from the batch_last transfer until the final result
// is loaded into the output register; the next batch may load while that
// result still waits.
// A receiver stall freezes the chain; no result is lost or repeated.
// Reset empties the chain and returns to loading; stored payload is not
// cleared.
module two_key_stable_sorter #(
	parameter int unsigned MAX_ITEMS = tksort_pkg::MAX_ITEMS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	tksort_in_if.sink     items,
	tksort_out_if.source  results
);

	localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);
	localparam int unsigned DRN_W = $clog2(MAX_ITEMS);
	localparam int unsigned SEQ_W = tksort_pkg::SEQ_W;

	tksort_pkg::state_t     state_q, state_d;
	logic [CNT_W-1:0]       fill_q;
	logic [DRN_W-1:0]       drain_q;
	logic                   ovf_q;

	logic                   in_xfer;
	logic                   full;
	logic                   out_free;
	logic                   emit_step;
	tksort_pkg::cell_ctrl_t ctrl;

	tksort_pkg::slot_t      held [MAX_ITEMS];
	tksort_pkg::slot_t      pass [MAX_ITEMS];
	tksort_pkg::slot_t      din0;

	// output register
	logic                   out_vld_q;
	tksort_pkg::entry_t     out_ent_q;
	logic                   out_last_q;
	logic                   out_drop_q;

	assign in_xfer  = items.valid && items.ready;
	assign full     = (fill_q == CNT_W'(MAX_ITEMS));
	assign out_free = !out_vld_q || results.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tksort_pkg::ST_LOAD: begin
				if (in_xfer && items.batch_last) begin
					state_d = tksort_pkg::ST_DRAIN;
				end
			end
			tksort_pkg::ST_DRAIN: begin
				if (drain_q == DRN_W'(MAX_ITEMS - 1)) begin
					state_d = tksort_pkg::ST_EMIT;
				end
			end
			tksort_pkg::ST_EMIT: begin
				if (out_free && fill_q == CNT_W'(1)) begin
					state_d = tksort_pkg::ST_LOAD;
				end
			end
			default: state_d = tksort_pkg::ST_LOAD;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		items.ready = 1'b0;
		emit_step   = 1'b0;
		unique case (state_q)
			tksort_pkg::ST_LOAD:  items.ready = 1'b1;
			tksort_pkg::ST_DRAIN: ;
			tksort_pkg::ST_EMIT:  emit_step = out_free;
			default: ;
		endcase
	end

	assign ctrl.shift = emit_step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tksort_pkg::ST_LOAD;
			fill_q  <= '0;
			drain_q <= '0;
			ovf_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_xfer) begin
				if (full) begin
					ovf_q <= 1'b1;
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
				drain_q <= '0;
			end else if (state_q == tksort_pkg::ST_DRAIN) begin
				drain_q <= drain_q + DRN_W'(1);
			end
			if (emit_step) begin
				fill_q <= fill_q - CNT_W'(1);
				if (fill_q == CNT_W'(1)) begin
					ovf_q <= 1'b0;
				end
			end
		end
	end

	// new entry enters cell 0 only while there is room; fill count is its arrival index
	assign din0.vld         = in_xfer && !full;
	assign din0.seq         = SEQ_W'(fill_q);
	assign din0.ent.tag     = items.item_tag;
	assign din0.ent.primary = items.primary_key;
	assign din0.ent.name    = items.name_key;

	// insertion chain: cell 0 holds the smallest entry
	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		tksort_pkg::slot_t cin;
		tksort_pkg::slot_t cnx;
		if (k == 0) begin : g_first
			assign cin = din0;
		end else begin : g_mid
			assign cin = pass[k-1];
		end
		if (k == MAX_ITEMS - 1) begin : g_end
			assign cnx = '{vld: 1'b0, seq: held[k].seq, ent: held[k].ent};
		end else begin : g_nxt
			assign cnx = held[k+1];
		end
		tksort_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctrl   (ctrl),
			.din    (cin),
			.nxt    (cnx),
			.held   (held[k]),
			.pass   (pass[k])
		);
	end

	// output register; dropped flag is sampled while the batch is unloaded
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_step) begin
			out_vld_q <= 1'b1;
		end else if (results.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_step) begin
			out_ent_q  <= held[0].ent;
			out_last_q <= (fill_q == CNT_W'(1));
			out_drop_q <= ovf_q;
		end
	end

	assign results.valid        = out_vld_q;
	assign results.out_tag      = out_ent_q.tag;
	assign results.out_primary  = out_ent_q.primary;
	assign results.out_name     = out_ent_q.name;
	assign results.out_last     = out_last_q;
	assign results.dropped_flag = out_drop_q;

endmodule

// ===== rtl/tksort_checker.sv =====
module tksort_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        in_last,
	input logic        out_valid,
	input logic        out_ready,
	input logic [79:0] out_data,
	input logic        out_last
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data) && $stable(out_last))
		else $error("result changed while stalled");

	// loading stops once the batch is closed
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("item taken after batch_last");

	// mid-batch result means the batch is still being unloaded
	a_unload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> !in_ready)
		else $error("loading during unload");

endmodule

bind two_key_stable_sorter tksort_checker u_tksort_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (items.valid),
	.in_ready  (items.ready),
	.in_last   (items.batch_last),
	.out_valid (results.valid),
	.out_ready (results.ready),
	.out_data  ({results.out_tag, results.out_primary, results.out_name}),
	.out_last  (results.out_last)
);
